// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the tangent generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TNG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Next-cycle implication: when pre holds, post holds in the next cycle.
`define TNG_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/core/tng_pkg.sv
// ----------------------------------------------------------------------------
// tng_pkg
// Types, widths and the multiply-accumulate program of the tangent generator.
// ----------------------------------------------------------------------------
package tng_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int MUL_A_W    = 34;
   localparam int MUL_B_W    = 32;
   localparam int ACC_W      = 64;
   localparam int WIDE_W     = 60;
   localparam int SCALED_W   = 24;
   localparam int PROJ_W     = 28;
   localparam int CROSS_W    = 33;
   localparam int ROOT_IN_W  = 56;
   localparam int ROOT_W     = 28;
   localparam int DIV_NUM_W  = 42;
   localparam int QUO_W      = 16;
   localparam int OP_W       = 5;

   localparam logic [ROOT_IN_W-1:0] ROOT_START_BIT = {2'b01, {(ROOT_IN_W-2){1'b0}}};

   localparam logic [OP_W-1:0] OP_TRI_FIRST    = 5'd0;
   localparam logic [OP_W-1:0] OP_TRI_LAST     = 5'd13;
   localparam logic [OP_W-1:0] OP_CORNER_FIRST = 5'd14;
   localparam logic [OP_W-1:0] OP_LEN2         = 5'd22;
   localparam logic [OP_W-1:0] OP_CROSS_FIRST  = 5'd23;
   localparam logic [OP_W-1:0] OP_LAST         = 5'd31;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [23:0] uv_u;
      logic signed [23:0] uv_v;
      logic signed [15:0] nrm_x;
      logic signed [15:0] nrm_y;
      logic signed [15:0] nrm_z;
      logic               restart;
   } tng_req_type;

   typedef struct packed {
      logic signed [15:0] tan_x;
      logic signed [15:0] tan_y;
      logic signed [15:0] tan_z;
      logic [1:0]         corner;
      logic               degenerate;
      logic               last;
   } tng_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MUL,
      ST_ACC,
      ST_SCALE,
      ST_CORNER,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [4:0] {
      A_DU1, A_DV1,
      A_DP1X, A_DP1Y, A_DP1Z,
      A_DP2X, A_DP2Y, A_DP2Z,
      A_NX, A_NY, A_NZ,
      A_U0, A_U1, A_U2,
      A_C0, A_C1, A_C2
   } a_sel_type;

   typedef enum logic [4:0] {
      B_DU1, B_DU2, B_DV1, B_DV2,
      B_TS0, B_TS1, B_TS2,
      B_BS0, B_BS1, B_BS2,
      B_P,
      B_U0, B_U1, B_U2,
      B_T0, B_T1, B_T2
   } b_sel_type;

   typedef enum logic [4:0] {
      D_NONE, D_DET,
      D_TR0, D_TR1, D_TR2,
      D_BR0, D_BR1, D_BR2,
      D_P,
      D_U0, D_U1, D_U2,
      D_LEN2,
      D_C0, D_C1, D_C2,
      D_D
   } dst_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      sub;
      logic      first;
      dst_type   dst;
   } mac_op_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic first;
      logic sub;
   } mac_ctrl_type;

   // One entry per multiply. Triangle setup first, then the per-corner part.
   function automatic mac_op_type mac_prog(input logic [OP_W-1:0] idx);
      mac_op_type op;
      case (idx)
         5'd0:  op = '{A_DU1,  B_DV2, 1'b0, 1'b1, D_NONE};
         5'd1:  op = '{A_DV1,  B_DU2, 1'b1, 1'b0, D_DET};
         5'd2:  op = '{A_DP1X, B_DV2, 1'b0, 1'b1, D_NONE};
         5'd3:  op = '{A_DP2X, B_DV1, 1'b1, 1'b0, D_TR0};
         5'd4:  op = '{A_DP1Y, B_DV2, 1'b0, 1'b1, D_NONE};
         5'd5:  op = '{A_DP2Y, B_DV1, 1'b1, 1'b0, D_TR1};
         5'd6:  op = '{A_DP1Z, B_DV2, 1'b0, 1'b1, D_NONE};
         5'd7:  op = '{A_DP2Z, B_DV1, 1'b1, 1'b0, D_TR2};
         5'd8:  op = '{A_DP2X, B_DU1, 1'b0, 1'b1, D_NONE};
         5'd9:  op = '{A_DP1X, B_DU2, 1'b1, 1'b0, D_BR0};
         5'd10: op = '{A_DP2Y, B_DU1, 1'b0, 1'b1, D_NONE};
         5'd11: op = '{A_DP1Y, B_DU2, 1'b1, 1'b0, D_BR1};
         5'd12: op = '{A_DP2Z, B_DU1, 1'b0, 1'b1, D_NONE};
         5'd13: op = '{A_DP1Z, B_DU2, 1'b1, 1'b0, D_BR2};
         5'd14: op = '{A_NX,   B_TS0, 1'b0, 1'b1, D_NONE};
         5'd15: op = '{A_NY,   B_TS1, 1'b0, 1'b0, D_NONE};
         5'd16: op = '{A_NZ,   B_TS2, 1'b0, 1'b0, D_P};
         5'd17: op = '{A_NX,   B_P,   1'b0, 1'b1, D_U0};
         5'd18: op = '{A_NY,   B_P,   1'b0, 1'b1, D_U1};
         5'd19: op = '{A_NZ,   B_P,   1'b0, 1'b1, D_U2};
         5'd20: op = '{A_U0,   B_U0,  1'b0, 1'b1, D_NONE};
         5'd21: op = '{A_U1,   B_U1,  1'b0, 1'b0, D_NONE};
         5'd22: op = '{A_U2,   B_U2,  1'b0, 1'b0, D_LEN2};
         5'd23: op = '{A_NY,   B_T2,  1'b0, 1'b1, D_NONE};
         5'd24: op = '{A_NZ,   B_T1,  1'b1, 1'b0, D_C0};
         5'd25: op = '{A_NZ,   B_T0,  1'b0, 1'b1, D_NONE};
         5'd26: op = '{A_NX,   B_T2,  1'b1, 1'b0, D_C1};
         5'd27: op = '{A_NX,   B_T1,  1'b0, 1'b1, D_NONE};
         5'd28: op = '{A_NY,   B_T0,  1'b1, 1'b0, D_C2};
         5'd29: op = '{A_C0,   B_BS0, 1'b0, 1'b1, D_NONE};
         5'd30: op = '{A_C1,   B_BS1, 1'b0, 1'b0, D_NONE};
         5'd31: op = '{A_C2,   B_BS2, 1'b0, 1'b0, D_D};
         default: op = '{A_DU1, B_DU1, 1'b0, 1'b1, D_NONE};
      endcase
      return op;
   endfunction

endpackage

// File: rtl/core/triangle_tangent_generator.sv
// ----------------------------------------------------------------------------
// triangle_tangent_generator
// Per-triangle tangent generation with Gram-Schmidt orthogonalization.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer, three to a triangle, and restart marks the
// first corner. The first two corners are only stored. The third corner starts
// the triangle computation and the block stays busy until the third tangent has
// been placed in the output register: the shared multiplier runs 14 setup
// products and 18 per-corner products, block scaling shifts one bit per cycle,
// and every corner with a nonzero projected tangent runs a square root and three
// divisions. A triangle with zero UV determinant is much faster, since only
// three degenerate transfers are produced. Tangents are Q2.14 unit vectors.
// ----------------------------------------------------------------------------
module triangle_tangent_generator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tng_pkg::tng_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tng_pkg::tng_rsp_type  rsp_data
);
   import tng_pkg::*;

   // Sequencer state.
   seq_state_type     state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [1:0]        corner_ff, corner_in;
   logic [1:0]        comp_ff, comp_in;
   logic [1:0]        cnt_ff;
   logic [1:0]        store_idx;

   // Vertex store: two held corners plus the closing one.
   logic signed [31:0] px_ff [3];
   logic signed [31:0] py_ff [3];
   logic signed [31:0] pz_ff [3];
   logic signed [23:0] tu_ff [3];
   logic signed [23:0] tv_ff [3];
   logic signed [15:0] nx_ff [3];
   logic signed [15:0] ny_ff [3];
   logic signed [15:0] nz_ff [3];

   // Triangle and corner intermediates.
   logic signed [32:0]          dp1x_ff, dp1y_ff, dp1z_ff;
   logic signed [32:0]          dp2x_ff, dp2y_ff, dp2z_ff;
   logic signed [24:0]          du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic                        det_neg_ff, det_zero_ff;
   logic signed [WIDE_W-1:0]    tr_ff [3];
   logic signed [WIDE_W-1:0]    br_ff [3];
   logic signed [SCALED_W-1:0]  ts [3];
   logic signed [SCALED_W-1:0]  bs [3];
   logic signed [PROJ_W-1:0]    p_ff;
   logic signed [PROJ_W-1:0]    uu_ff [3];
   logic [ROOT_IN_W-1:0]        len2_ff;
   logic signed [15:0]          t_ff [3];
   logic signed [CROSS_W-1:0]   c_ff [3];
   logic                        d_neg_ff;
   logic                        deg_ff;

   // Shared arithmetic.
   mac_op_type                  op;
   mac_ctrl_type                mac_ctrl;
   logic signed [MUL_A_W-1:0]   a_op;
   logic signed [MUL_B_W-1:0]   b_op;
   logic signed [ACC_W-1:0]     sum;
   logic signed [ACC_W-1:0]     prod;
   logic signed [ACC_W-1:0]     sum_shr;
   logic signed [ACC_W-1:0]     prod_shr;
   logic                        t_fit, b_fit;

   // Root and divider.
   logic                        sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]           root;
   logic                        div_start, div_done;
   logic [QUO_W-1:0]            quo;
   logic [PROJ_W-1:0]           mag;
   logic [DIV_NUM_W-1:0]        div_num;
   logic [QUO_W-1:0]            q_sat;
   logic signed [15:0]          t_new;

   // Output register.
   logic                        rsp_valid_ff;
   tng_rsp_type                 rsp_data_ff;
   logic                        rsp_load;
   logic signed [15:0]          out_x, out_y, out_z;

   assign store_idx = req_data.restart ? 2'd0 : cnt_ff;
   assign op        = mac_prog(op_ff);
   assign sum_shr   = sum >>> FRAC_BITS;
   assign prod_shr  = prod >>> FRAC_BITS;

   // After block scaling each wide vector sits in the low 24 bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ts[i] = tr_ff[i][SCALED_W-1:0];
         bs[i] = br_ff[i][SCALED_W-1:0];
      end
   end

   // A vector fits once the bits above the scaled width are pure sign bits.
   always_comb begin
      t_fit = 1'b1;
      b_fit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (!((&tr_ff[i][WIDE_W-1:SCALED_W-1]) || !(|tr_ff[i][WIDE_W-1:SCALED_W-1]))) begin
            t_fit = 1'b0;
         end
         if (!((&br_ff[i][WIDE_W-1:SCALED_W-1]) || !(|br_ff[i][WIDE_W-1:SCALED_W-1]))) begin
            b_fit = 1'b0;
         end
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (op.a_sel)
         A_DU1:   a_op = MUL_A_W'(du1_ff);
         A_DV1:   a_op = MUL_A_W'(dv1_ff);
         A_DP1X:  a_op = MUL_A_W'(dp1x_ff);
         A_DP1Y:  a_op = MUL_A_W'(dp1y_ff);
         A_DP1Z:  a_op = MUL_A_W'(dp1z_ff);
         A_DP2X:  a_op = MUL_A_W'(dp2x_ff);
         A_DP2Y:  a_op = MUL_A_W'(dp2y_ff);
         A_DP2Z:  a_op = MUL_A_W'(dp2z_ff);
         A_NX:    a_op = MUL_A_W'(nx_ff[corner_ff]);
         A_NY:    a_op = MUL_A_W'(ny_ff[corner_ff]);
         A_NZ:    a_op = MUL_A_W'(nz_ff[corner_ff]);
         A_U0:    a_op = MUL_A_W'(uu_ff[0]);
         A_U1:    a_op = MUL_A_W'(uu_ff[1]);
         A_U2:    a_op = MUL_A_W'(uu_ff[2]);
         A_C0:    a_op = MUL_A_W'(c_ff[0]);
         A_C1:    a_op = MUL_A_W'(c_ff[1]);
         A_C2:    a_op = MUL_A_W'(c_ff[2]);
         default: a_op = '0;
      endcase
      case (op.b_sel)
         B_DU1:   b_op = MUL_B_W'(du1_ff);
         B_DU2:   b_op = MUL_B_W'(du2_ff);
         B_DV1:   b_op = MUL_B_W'(dv1_ff);
         B_DV2:   b_op = MUL_B_W'(dv2_ff);
         B_TS0:   b_op = MUL_B_W'(ts[0]);
         B_TS1:   b_op = MUL_B_W'(ts[1]);
         B_TS2:   b_op = MUL_B_W'(ts[2]);
         B_BS0:   b_op = MUL_B_W'(bs[0]);
         B_BS1:   b_op = MUL_B_W'(bs[1]);
         B_BS2:   b_op = MUL_B_W'(bs[2]);
         B_P:     b_op = MUL_B_W'(p_ff);
         B_U0:    b_op = MUL_B_W'(uu_ff[0]);
         B_U1:    b_op = MUL_B_W'(uu_ff[1]);
         B_U2:    b_op = MUL_B_W'(uu_ff[2]);
         B_T0:    b_op = MUL_B_W'(t_ff[0]);
         B_T1:    b_op = MUL_B_W'(t_ff[1]);
         B_T2:    b_op = MUL_B_W'(t_ff[2]);
         default: b_op = '0;
      endcase
   end

   tng_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .a_op  (a_op),
      .b_op  (b_op),
      .sum   (sum),
      .prod  (prod)
   );

   tng_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (len2_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   // Rounded quotient: (|u| * 2^14 + L/2) / L.
   assign mag     = uu_ff[comp_ff][PROJ_W-1] ? PROJ_W'(-uu_ff[comp_ff])
                                             : PROJ_W'(uu_ff[comp_ff]);
   assign div_num = {mag, {FRAC_BITS{1'b0}}} + DIV_NUM_W'(root >> 1);

   tng_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (root),
      .done  (div_done),
      .quo   (quo)
   );

   assign q_sat = quo[QUO_W-1] ? 16'h7fff : quo;
   assign t_new = uu_ff[comp_ff][PROJ_W-1] ? -$signed(q_sat) : $signed(q_sat);

   // Sequencer: next state and unit controls.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      corner_in  = corner_ff;
      comp_in    = comp_ff;
      mac_ctrl   = '0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (store_idx == 2'd2)) begin
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            op_in    = OP_TRI_FIRST;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            state_in        = ST_ACC;
         end
         ST_ACC: begin
            mac_ctrl.acc_en = 1'b1;
            mac_ctrl.first  = op.first;
            mac_ctrl.sub    = op.sub;
            if (op_ff == OP_TRI_LAST) begin
               state_in = ST_SCALE;
            end else if (op_ff == OP_LEN2) begin
               state_in = (sum == '0) ? ST_EMIT : ST_SQRT_GO;
            end else if (op_ff == OP_LAST) begin
               state_in = ST_EMIT;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_SCALE: begin
            if (t_fit && b_fit) begin
               corner_in = 2'd0;
               state_in  = ST_CORNER;
            end
         end
         ST_CORNER: begin
            if (det_zero_ff) begin
               state_in = ST_EMIT;
            end else begin
               op_in    = OP_CORNER_FIRST;
               state_in = ST_MUL;
            end
         end
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               comp_in  = 2'd0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (comp_ff == 2'd2) begin
                  op_in    = OP_CROSS_FIRST;
                  state_in = ST_MUL;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (corner_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  corner_in = corner_ff + 2'd1;
                  state_in  = ST_CORNER;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         corner_ff    <= '0;
         comp_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         corner_ff <= corner_in;
         comp_ff   <= comp_in;
         if (req_valid && req_ready) begin
            cnt_ff <= (store_idx == 2'd2) ? 2'd0 : store_idx + 2'd1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Vertex capture. A restart simply overwrites corner zero.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         px_ff[store_idx] <= req_data.pos_x;
         py_ff[store_idx] <= req_data.pos_y;
         pz_ff[store_idx] <= req_data.pos_z;
         tu_ff[store_idx] <= req_data.uv_u;
         tv_ff[store_idx] <= req_data.uv_v;
         nx_ff[store_idx] <= req_data.nrm_x;
         ny_ff[store_idx] <= req_data.nrm_y;
         nz_ff[store_idx] <= req_data.nrm_z;
      end
   end

   // Datapath registers written by the sequencer.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_DELTA: begin
            dp1x_ff <= 33'(px_ff[1]) - 33'(px_ff[0]);
            dp1y_ff <= 33'(py_ff[1]) - 33'(py_ff[0]);
            dp1z_ff <= 33'(pz_ff[1]) - 33'(pz_ff[0]);
            dp2x_ff <= 33'(px_ff[2]) - 33'(px_ff[0]);
            dp2y_ff <= 33'(py_ff[2]) - 33'(py_ff[0]);
            dp2z_ff <= 33'(pz_ff[2]) - 33'(pz_ff[0]);
            du1_ff  <= 25'(tu_ff[1]) - 25'(tu_ff[0]);
            dv1_ff  <= 25'(tv_ff[1]) - 25'(tv_ff[0]);
            du2_ff  <= 25'(tu_ff[2]) - 25'(tu_ff[0]);
            dv2_ff  <= 25'(tv_ff[2]) - 25'(tv_ff[0]);
         end
         ST_ACC: begin
            // The raw tangent and bitangent take the sign of the determinant.
            case (op.dst)
               D_DET: begin
                  det_neg_ff  <= sum[ACC_W-1];
                  det_zero_ff <= (sum == '0);
               end
               D_TR0:  tr_ff[0] <= det_neg_ff ? -WIDE_W'(sum) : WIDE_W'(sum);
               D_TR1:  tr_ff[1] <= det_neg_ff ? -WIDE_W'(sum) : WIDE_W'(sum);
               D_TR2:  tr_ff[2] <= det_neg_ff ? -WIDE_W'(sum) : WIDE_W'(sum);
               D_BR0:  br_ff[0] <= det_neg_ff ? -WIDE_W'(sum) : WIDE_W'(sum);
               D_BR1:  br_ff[1] <= det_neg_ff ? -WIDE_W'(sum) : WIDE_W'(sum);
               D_BR2:  br_ff[2] <= det_neg_ff ? -WIDE_W'(sum) : WIDE_W'(sum);
               D_P:    p_ff <= PROJ_W'(sum_shr);
               D_U0:   uu_ff[0] <= PROJ_W'(ts[0]) - PROJ_W'(prod_shr);
               D_U1:   uu_ff[1] <= PROJ_W'(ts[1]) - PROJ_W'(prod_shr);
               D_U2:   uu_ff[2] <= PROJ_W'(ts[2]) - PROJ_W'(prod_shr);
               D_LEN2: begin
                  len2_ff <= sum[ROOT_IN_W-1:0];
                  deg_ff  <= (sum == '0);
               end
               D_C0:   c_ff[0] <= CROSS_W'(sum);
               D_C1:   c_ff[1] <= CROSS_W'(sum);
               D_C2:   c_ff[2] <= CROSS_W'(sum);
               D_D:    d_neg_ff <= sum[ACC_W-1];
               default: begin
               end
            endcase
         end
         ST_SCALE: begin
            // Floor shifts by one bit per cycle until all components fit.
            for (int i = 0; i < 3; i++) begin
               if (!t_fit) begin
                  tr_ff[i] <= tr_ff[i] >>> 1;
               end
               if (!b_fit) begin
                  br_ff[i] <= br_ff[i] >>> 1;
               end
            end
         end
         ST_CORNER: begin
            deg_ff <= det_zero_ff;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               t_ff[comp_ff] <= t_new;
            end
         end
         default: begin
         end
      endcase
   end

   // Result formatting: degenerate corners give a zero tangent, and a
   // negative handedness test flips the tangent.
   always_comb begin
      if (deg_ff) begin
         out_x = '0;
         out_y = '0;
         out_z = '0;
      end else if (d_neg_ff) begin
         out_x = -t_ff[0];
         out_y = -t_ff[1];
         out_z = -t_ff[2];
      end else begin
         out_x = t_ff[0];
         out_y = t_ff[1];
         out_z = t_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.tan_x      <= out_x;
         rsp_data_ff.tan_y      <= out_y;
         rsp_data_ff.tan_z      <= out_z;
         rsp_data_ff.corner     <= corner_ff;
         rsp_data_ff.degenerate <= deg_ff;
         rsp_data_ff.last       <= (corner_ff == 2'd2);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "assert_macros.svh"

   `TNG_ASSERT(a_last_on_third, rsp_valid && rsp_data.last |-> rsp_data.corner == 2'd2, "last flag on a corner other than the third")
   `TNG_ASSERT(a_degenerate_zero, rsp_valid && rsp_data.degenerate |-> rsp_data.tan_x == 16'sd0 && rsp_data.tan_y == 16'sd0 && rsp_data.tan_z == 16'sd0, "degenerate transfer with nonzero tangent")
   `TNG_ASSERT(a_unit_bound, rsp_valid && !rsp_data.degenerate |-> rsp_data.tan_x <= 16'sd16384 && rsp_data.tan_x >= -16'sd16384, "tangent component exceeds unit length")
   `TNG_ASSERT(a_root_when_waited, sqrt_done |-> state_ff == ST_SQRT_WAIT, "square root finished outside its wait state")
   `TNG_ASSERT_NEXT(a_root_then_divide, sqrt_done, state_ff == ST_DIV_GO, "division did not follow the square root")

endmodule

// File: rtl/core/tng_mac.sv
// ----------------------------------------------------------------------------
// tng_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module tng_mac (
   input  logic                                 clock,
   input  tng_pkg::mac_ctrl_type                ctrl,
   input  logic signed [tng_pkg::MUL_A_W-1:0]   a_op,
   input  logic signed [tng_pkg::MUL_B_W-1:0]   b_op,
   output logic signed [tng_pkg::ACC_W-1:0]     sum,
   output logic signed [tng_pkg::ACC_W-1:0]     prod
);
   import tng_pkg::*;

   logic signed [MUL_A_W+MUL_B_W-1:0] full;
   logic signed [ACC_W-1:0]           prod_ff;
   logic signed [ACC_W-1:0]           acc_ff;
   logic signed [ACC_W-1:0]           base;
   logic signed [ACC_W-1:0]           addend;

   assign full   = a_op * b_op;
   assign base   = ctrl.first ? '0 : acc_ff;
   assign addend = ctrl.sub ? -prod_ff : prod_ff;
   assign sum    = base + addend;
   assign prod   = prod_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= full[ACC_W-1:0];
      end
      if (ctrl.acc_en) begin
         acc_ff <= sum;
      end
   end

endmodule

// File: rtl/core/tng_sqrt.sv
// ----------------------------------------------------------------------------
// tng_sqrt
// Integer square root, two radicand bits per clock.
// ----------------------------------------------------------------------------
module tng_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [tng_pkg::ROOT_IN_W-1:0]      radicand,
   output logic                               done,
   output logic [tng_pkg::ROOT_W-1:0]         root
);
   import tng_pkg::*;

   logic [ROOT_IN_W-1:0] rem_ff, rem_in;
   logic [ROOT_IN_W-1:0] res_ff, res_in;
   logic [ROOT_IN_W-1:0] bit_ff;
   logic [ROOT_IN_W-1:0] trial;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 ge;

   assign trial  = res_ff + bit_ff;
   assign ge     = rem_ff >= trial;
   assign rem_in = ge ? rem_ff - trial : rem_ff;
   assign res_in = ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
   assign done   = done_ff;
   assign root   = res_ff[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && bit_ff[0];
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= radicand;
         res_ff <= '0;
         bit_ff <= ROOT_START_BIT;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

// File: rtl/core/tng_div.sv
// ----------------------------------------------------------------------------
// tng_div
// Restoring divider, one quotient bit per clock, for a quotient below 2^16.
// ----------------------------------------------------------------------------
module tng_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [tng_pkg::DIV_NUM_W-1:0]      num,
   input  logic [tng_pkg::ROOT_W-1:0]         den,
   output logic                               done,
   output logic [tng_pkg::QUO_W-1:0]          quo
);
   import tng_pkg::*;

   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] den_ff;
   logic [QUO_W-1:0]  low_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [3:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W:0]   shifted;
   logic [ROOT_W:0]   diff;
   logic              ge;

   assign shifted = {rem_ff, low_ff[QUO_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};
   assign rem_in  = ge ? diff[ROOT_W-1:0] : shifted[ROOT_W-1:0];
   assign done    = done_ff;
   assign quo     = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= ROOT_W'(num >> QUO_W);
         low_ff <= num[QUO_W-1:0];
         den_ff <= den;
         quo_ff <= '0;
         cnt_ff <= 4'd15;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_ff << 1;
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
         cnt_ff <= cnt_ff - 4'd1;
      end
   end

endmodule
